FILE: hdl/acia_pkg.sv
// Package for the cassette ACIA: transfer item types, command and register codes,
// status layout and word-select frame lookup. No dependencies.
`default_nettype none

package acia_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_REWIND = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_PERIOD     = 2'd0;
  localparam logic [1:0] CFG_INPUT_ATTACHED  = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_ATTACHED = 2'd2;
  localparam logic [1:0] CFG_ACTIVITY_LIMIT  = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [15:0] BASE_PERIOD_RST    = 16'd13653;
  localparam logic [9:0]  ACTIVITY_LIMIT_RST = 10'd300;

  // control register divider field
  localparam logic [1:0] DIV_SEL_1        = 2'd0;
  localparam logic [1:0] DIV_SEL_16       = 2'd1;
  localparam logic [1:0] DIV_SEL_64       = 2'd2;
  localparam logic [1:0] DIV_MASTER_RESET = 2'd3;

  localparam logic [6:0] DIV_BY_1  = 7'd1;
  localparam logic [6:0] DIV_BY_16 = 7'd16;
  localparam logic [6:0] DIV_BY_64 = 7'd64;

  localparam logic [3:0] FRAME_LONG  = 4'd11;
  localparam logic [3:0] FRAME_SHORT = 4'd10;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tick_cycles;
    logic       reg_select;
    logic [7:0] write_data;
    logic       tape_in_valid;
    logic [7:0] tape_in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tape_in_take;
    logic       tape_out_valid;
    logic [7:0] tape_out_byte;
    logic       rewind_request;
    logic       running;
  } out_item_t;

  // frame length in bit times for a word-select code
  function automatic logic [3:0] frame_len(input logic [2:0] word_sel);
    logic [3:0] len;
    case (word_sel)
      3'd2, 3'd3, 3'd5: len = FRAME_SHORT;
      default:          len = FRAME_LONG;
    endcase
    return len;
  endfunction

  // status byte: bit 0 RDRF, 1 TDRE, 4 FE, 5 OVRN
  function automatic logic [7:0] status_byte(input logic rdrf, input logic tdre,
                                             input logic fe, input logic ovrn);
    return {2'b00, ovrn, fe, 2'b00, tdre, rdrf};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/acia_if.sv
// Channel interfaces for the cassette ACIA: event input, result output and
// configuration write. Depends on acia_pkg.
`default_nettype none

interface acia_in_if;
  logic               valid;
  logic               ready;
  acia_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface acia_out_if;
  logic                valid;
  logic                ready;
  acia_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface acia_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/acia_tape_interface.sv
// Top level of the 6850-style cassette serial port. Depends on acia_pkg and
// the channel interfaces in acia_if.sv.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    command, tick_cycles, reg_select, write_data,
//                                 tape_in_valid, tape_in_byte
//   out_ch    out  valid/ready    read_data, tape_in_take, tape_out_valid,
//                                 tape_out_byte, rewind_request, running
//   cfg       in   valid/ready    reg_index, reg_data
//
// One event per clock: the whole update is done in the accepting cycle and the
// result lands in the output register, visible the next cycle.
// Throughput is one transfer per cycle; the single output register sets it: a
// new event is taken whenever that register is empty or being drained.
// While out_ch stalls with a result pending, in_ch.ready drops and nothing moves.
// Synchronous active-high rst puts all state and configuration at reset values, except the result payload register.
// cfg is always ready; writes are expected only while the port is idle.
`default_nettype none

module acia_tape_interface (
  input  wire   clk,
  input  wire   rst,
  acia_in_if.sink    in_ch,
  acia_out_if.source out_ch,
  acia_cfg_if.sink   cfg
);
  import acia_pkg::*;

  // configuration
  logic [15:0] base_period;
  logic        input_attached;
  logic        output_attached;
  logic [9:0]  activity_limit;

  // port state
  logic [23:0] cycle_accum;
  logic        motor_on;
  logic        mode_reading;
  logic        mode_writing;
  logic        st_rdrf, st_tdre, st_fe, st_ovrn;
  logic [7:0]  receive_byte;
  logic [7:0]  transmit_byte;
  logic [3:0]  bits_left;
  logic [3:0]  bits_per_frame;
  logic [6:0]  divider_count;
  logic [6:0]  divider_value;
  logic [9:0]  activity_left;

  logic        out_valid;
  out_item_t   out_item;

  logic [23:0] cycle_accum_next;
  logic        motor_on_next, mode_reading_next, mode_writing_next;
  logic        st_rdrf_next, st_tdre_next, st_fe_next, st_ovrn_next;
  logic [7:0]  receive_byte_next, transmit_byte_next;
  logic [3:0]  bits_left_next, bits_per_frame_next;
  logic [6:0]  divider_count_next, divider_value_next;
  logic [9:0]  activity_left_next;
  out_item_t   res;

  logic [24:0] accum_sum;
  logic [23:0] accum_sat;
  logic        base_tick;
  logic [6:0]  div_dec;
  logic        in_fire;
  in_item_t    it;

  assign it           = in_ch.item;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  // accumulator in Q16.8 cycles, saturating, at most one base tick per event
  assign accum_sum = {1'b0, cycle_accum} + {1'b0, 8'd0, it.tick_cycles, 8'd0};
  assign accum_sat = accum_sum[24] ? '1 : accum_sum[23:0];
  assign base_tick = accum_sat >= {8'd0, base_period};
  assign div_dec   = divider_count - 7'd1;

  always_comb begin
    cycle_accum_next    = cycle_accum;
    motor_on_next       = motor_on;
    mode_reading_next   = mode_reading;
    mode_writing_next   = mode_writing;
    st_rdrf_next        = st_rdrf;
    st_tdre_next        = st_tdre;
    st_fe_next          = st_fe;
    st_ovrn_next        = st_ovrn;
    receive_byte_next   = receive_byte;
    transmit_byte_next  = transmit_byte;
    bits_left_next      = bits_left;
    bits_per_frame_next = bits_per_frame;
    divider_count_next  = divider_count;
    divider_value_next  = divider_value;
    activity_left_next  = activity_left;
    res                 = '0;

    case (it.command)
      CMD_TICK: begin
        cycle_accum_next = accum_sat;
        if (base_tick) begin
          cycle_accum_next = accum_sat - {8'd0, base_period};
          // divider stays at zero until the first control write that selects a ratio
          if (motor_on && divider_count != 7'd0) begin
            divider_count_next = div_dec;
            if (div_dec == 7'd0) begin
              divider_count_next = divider_value;
              if (bits_left > 4'd1) begin
                bits_left_next = bits_left - 4'd1;
              end else begin
                // byte slot
                bits_left_next = 4'd0;
                if (mode_reading && input_attached) begin
                  if (it.tape_in_valid) begin
                    st_fe_next        = 1'b0;
                    receive_byte_next = it.tape_in_byte;
                    st_ovrn_next      = st_rdrf;
                    st_rdrf_next      = 1'b1;
                    res.tape_in_take  = 1'b1;
                  end else begin
                    st_fe_next = 1'b1;
                  end
                  bits_left_next = bits_per_frame;
                end
                if (mode_writing && output_attached) begin
                  if (!st_tdre) begin
                    res.tape_out_valid = 1'b1;
                    res.tape_out_byte  = transmit_byte;
                    st_tdre_next       = 1'b1;
                  end
                  bits_left_next = bits_per_frame;
                end
                if (activity_left == 10'd0) begin
                  motor_on_next = 1'b0;
                end else begin
                  activity_left_next = activity_left - 10'd1;
                end
              end
            end
          end
        end
      end
      CMD_READ: begin
        activity_left_next = activity_limit;
        if (!it.reg_select) begin
          // status read spins the tape up in reading mode
          if (!motor_on) begin
            motor_on_next     = 1'b1;
            mode_reading_next = 1'b1;
          end
          res.read_data = status_byte(st_rdrf, st_tdre, st_fe, st_ovrn);
        end else begin
          st_rdrf_next  = 1'b0;
          st_ovrn_next  = 1'b0;
          res.read_data = receive_byte;
        end
      end
      CMD_WRITE: begin
        activity_left_next = activity_limit;
        if (!it.reg_select) begin
          case (it.write_data[1:0])
            DIV_MASTER_RESET: begin
              motor_on_next = 1'b0;
              st_rdrf_next  = 1'b0;
              st_tdre_next  = 1'b1;
              st_fe_next    = 1'b0;
              st_ovrn_next  = 1'b0;
            end
            DIV_SEL_16: begin
              divider_value_next = DIV_BY_16;
              divider_count_next = DIV_BY_16;
            end
            DIV_SEL_64: begin
              divider_value_next = DIV_BY_64;
              divider_count_next = DIV_BY_64;
            end
            default: begin
              divider_value_next = DIV_BY_1;
              divider_count_next = DIV_BY_1;
            end
          endcase
          bits_per_frame_next = frame_len(it.write_data[4:2]);
        end else if (motor_on) begin
          // first data write flips the tape to writing and requests an input rewind if input is attached
          if (!mode_writing) begin
            res.rewind_request = input_attached;
            mode_reading_next  = 1'b0;
            mode_writing_next  = 1'b1;
          end
          transmit_byte_next = it.write_data;
          st_tdre_next       = 1'b0;
        end
      end
      default: begin
        res.rewind_request = input_attached;
        motor_on_next      = 1'b0;
        mode_reading_next  = 1'b0;
        mode_writing_next  = 1'b0;
      end
    endcase

    res.running = motor_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_period     <= BASE_PERIOD_RST;
      input_attached  <= 1'b1;
      output_attached <= 1'b1;
      activity_limit  <= ACTIVITY_LIMIT_RST;
      cycle_accum     <= '0;
      motor_on        <= 1'b0;
      mode_reading    <= 1'b0;
      mode_writing    <= 1'b0;
      st_rdrf         <= 1'b0;
      st_tdre         <= 1'b0;
      st_fe           <= 1'b0;
      st_ovrn         <= 1'b0;
      receive_byte    <= '0;
      transmit_byte   <= '0;
      bits_left       <= '0;
      bits_per_frame  <= FRAME_LONG;
      divider_count   <= '0;
      divider_value   <= '0;
      activity_left   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          CFG_BASE_PERIOD:     base_period     <= cfg.reg_data;
          CFG_INPUT_ATTACHED:  input_attached  <= cfg.reg_data[0];
          CFG_OUTPUT_ATTACHED: output_attached <= cfg.reg_data[0];
          CFG_ACTIVITY_LIMIT:  activity_limit  <= cfg.reg_data[9:0];
          default:             base_period     <= base_period;
        endcase
      end
      if (in_fire) begin
        cycle_accum    <= cycle_accum_next;
        motor_on       <= motor_on_next;
        mode_reading   <= mode_reading_next;
        mode_writing   <= mode_writing_next;
        st_rdrf        <= st_rdrf_next;
        st_tdre        <= st_tdre_next;
        st_fe          <= st_fe_next;
        st_ovrn        <= st_ovrn_next;
        receive_byte   <= receive_byte_next;
        transmit_byte  <= transmit_byte_next;
        bits_left      <= bits_left_next;
        bits_per_frame <= bits_per_frame_next;
        divider_count  <= divider_count_next;
        divider_value  <= divider_value_next;
        activity_left  <= activity_left_next;
        out_valid      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: payload only, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item <= res;
    end
  end

  // divider counter never runs past its reload value
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    divider_count <= divider_value)
    else $error("divider_count above divider_value");

  // a transmitted byte leaves the transmit register empty
  a_tx_sets_tdre: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.tape_out_valid |=> st_tdre)
    else $error("TDRE not set after tape output");

  // a held result blocks new events
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted over pending result");

  // rewind always stops the motor and reports it
  a_rewind_stops: assert property (@(posedge clk) disable iff (rst)
    in_fire && it.command == CMD_REWIND |=> !motor_on && out_valid && !out_item.running)
    else $error("motor still running after rewind");

endmodule

`default_nettype wire

FILE: sim/acia_tape_interface_tb.sv
`timescale 1ns / 1ps
// Testbench for acia_tape_interface: directed and random event streams, checked
// reply by reply against a cycle-free predictor of the port. Needs acia_pkg and acia_if.sv.

module acia_tape_interface_tb;
  import acia_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on any channel
  localparam int SETTLE_TAIL  = 8;     // tail after the last reply, to catch extra ones
  localparam int MAX_REPORTS  = 40;
  localparam logic [23:0] ACCUM_TOP = 24'hFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acia_in_if  in_ch ();
  acia_out_if out_ch ();
  acia_cfg_if cfg_ch ();

  acia_tape_interface DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the port and of its settings, reset values
  // as the port comes out of reset.
  // ---------------------------------------------------------------------------
  logic [15:0] c_period    = BASE_PERIOD_RST;
  logic        c_in_att    = 1'b1;
  logic        c_out_att   = 1'b1;
  logic [9:0]  c_act_limit = ACTIVITY_LIMIT_RST;

  logic [23:0] p_accum      = '0;
  logic        p_motor      = 1'b0;
  logic        p_reading    = 1'b0;
  logic        p_writing    = 1'b0;
  logic        p_rdrf       = 1'b0;
  logic        p_tdre       = 1'b0;
  logic        p_fe         = 1'b0;
  logic        p_ovrn       = 1'b0;
  logic [7:0]  p_rx_byte    = '0;
  logic [7:0]  p_tx_byte    = '0;
  logic [3:0]  p_bits_left  = '0;
  logic [3:0]  p_frame_bits = FRAME_LONG;
  logic [6:0]  p_div_count  = '0;   // zero keeps bit timing stalled
  logic [6:0]  p_div_value  = '0;
  logic [10:0] p_act_left   = '0;

  out_item_t replies_due[$];   // replies predicted and not yet seen
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;           // 1: no gaps on either side

  // Works out the reply to one accepted event and advances the predictor.
  function automatic out_item_t next_reply(in_item_t ev);
    out_item_t   rep;
    logic [24:0] sum;
    rep = '0;
    case (ev.command)
      CMD_TICK: begin
        // Q16.8 cycle accumulator, saturating, at most one base tick per event
        sum = {1'b0, p_accum} + {9'd0, ev.tick_cycles, 8'd0};
        p_accum = (sum > ACCUM_TOP) ? ACCUM_TOP : sum[23:0];
        if (p_accum >= {8'd0, c_period}) begin
          p_accum = p_accum - {8'd0, c_period};
          if (p_motor && p_div_count != 0) begin
            p_div_count = p_div_count - 7'd1;
            if (p_div_count == 0) begin
              // one bit time has passed
              p_div_count = p_div_value;
              if (p_bits_left > 1) begin
                p_bits_left = p_bits_left - 4'd1;
              end else begin
                // byte slot
                p_bits_left = '0;
                if (p_reading && c_in_att) begin
                  if (ev.tape_in_valid) begin
                    p_fe      = 1'b0;
                    p_rx_byte = ev.tape_in_byte;
                    p_ovrn    = p_rdrf;
                    p_rdrf    = 1'b1;
                    rep.tape_in_take = 1'b1;
                  end else begin
                    p_fe = 1'b1;   // end of tape
                  end
                  p_bits_left = p_frame_bits;
                end
                if (p_writing && c_out_att) begin
                  if (!p_tdre) begin
                    rep.tape_out_valid = 1'b1;
                    rep.tape_out_byte  = p_tx_byte;
                    p_tdre = 1'b1;
                  end
                  p_bits_left = p_frame_bits;
                end
                if (p_act_left == 0) p_motor = 1'b0;
                else p_act_left = p_act_left - 11'd1;
              end
            end
          end
        end
      end
      CMD_READ: begin
        p_act_left = {1'b0, c_act_limit};
        if (!ev.reg_select) begin
          if (!p_motor) begin
            p_motor   = 1'b1;
            p_reading = 1'b1;
          end
          rep.read_data = {2'b00, p_ovrn, p_fe, 2'b00, p_tdre, p_rdrf};
        end else begin
          p_rdrf = 1'b0;
          p_ovrn = 1'b0;
          rep.read_data = p_rx_byte;
        end
      end
      CMD_WRITE: begin
        p_act_left = {1'b0, c_act_limit};
        if (!ev.reg_select) begin
          case (ev.write_data[1:0])
            DIV_SEL_1:  begin p_div_value = DIV_BY_1;  p_div_count = DIV_BY_1;  end
            DIV_SEL_16: begin p_div_value = DIV_BY_16; p_div_count = DIV_BY_16; end
            DIV_SEL_64: begin p_div_value = DIV_BY_64; p_div_count = DIV_BY_64; end
            default: begin
              // master reset: motor off, status back to TDRE alone
              p_motor = 1'b0;
              p_rdrf  = 1'b0;
              p_fe    = 1'b0;
              p_ovrn  = 1'b0;
              p_tdre  = 1'b1;
            end
          endcase
          p_frame_bits = (ev.write_data[4:2] inside {3'd2, 3'd3, 3'd5}) ?
                         FRAME_SHORT : FRAME_LONG;
        end else if (p_motor) begin
          if (!p_writing) begin
            rep.rewind_request = c_in_att;
            p_reading = 1'b0;
            p_writing = 1'b1;
          end
          p_tx_byte = ev.write_data;
          p_tdre    = 1'b0;
        end
      end
      CMD_REWIND: begin
        rep.rewind_request = c_in_att;
        p_motor   = 1'b0;
        p_reading = 1'b0;
        p_writing = 1'b0;
      end
    endcase
    rep.running = p_motor;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // gap length for either side: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] pick_cycles();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // mostly /1 so byte slots come often; /64 is slow and rare
  function automatic logic [1:0] pick_divider();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return DIV_SEL_1;
    if (r < 88) return DIV_SEL_16;
    if (r < 92) return DIV_SEL_64;
    return DIV_MASTER_RESET;
  endfunction

  // every field random, including the ones the command ignores
  function automatic in_item_t any_item();
    logic [31:0] raw;
    in_item_t ev;
    raw = $urandom;
    ev  = in_item_t'(raw[$bits(in_item_t)-1:0]);
    return ev;
  endfunction

  function automatic in_item_t shaped_item(cmd_t cmd, logic sel);
    in_item_t ev;
    ev = any_item();
    ev.command    = cmd;
    ev.reg_select = sel;
    return ev;
  endfunction

  // tick with a mostly present tape byte; end of tape one time in ten
  function automatic in_item_t tick_item();
    in_item_t ev;
    ev = shaped_item(CMD_TICK, 1'($urandom));
    ev.tick_cycles   = pick_cycles();
    ev.tape_in_valid = ($urandom_range(0, 9) != 0);
    return ev;
  endfunction

  // One event transfer. valid is left high after the transfer when no gap
  // follows, so back-to-back events never drop and re-raise it in one step.
  task automatic send_event(in_item_t ev);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.item  <= ev;
    do @(posedge clk); while (!in_ch.ready);
    replies_due.push_back(next_reply(ev));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every predicted reply has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic cfg_put(logic [1:0] index, logic [15:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.reg_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CFG_BASE_PERIOD:     c_period    = data;
      CFG_INPUT_ATTACHED:  c_in_att    = data[0];
      CFG_OUTPUT_ATTACHED: c_out_att   = data[0];
      CFG_ACTIVITY_LIMIT:  c_act_limit = data[9:0];
      default: ;
    endcase
  endtask

  // all four registers, back to back, with the port idle
  task automatic configure(logic [15:0] period, logic in_att, logic out_att,
                           logic [9:0] limit);
    wait_drained();
    cfg_put(CFG_BASE_PERIOD, period);
    cfg_put(CFG_INPUT_ATTACHED, {15'd0, in_att});
    cfg_put(CFG_OUTPUT_ATTACHED, {15'd0, out_att});
    cfg_put(CFG_ACTIVITY_LIMIT, {6'd0, limit});
    cfg_ch.valid <= 1'b0;
  endtask

  // A well-formed opening (control write, status read to start the tape),
  // then a random mix weighted toward ticks, with some noise items and
  // occasional full drains before the next status poll.
  task automatic run_session(int count);
    in_item_t ev;
    int k;
    int pick;
    ev = shaped_item(CMD_WRITE, 1'b0);
    ev.write_data[1:0] = pick_divider();
    send_event(ev);
    send_event(shaped_item(CMD_READ, 1'b0));
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 199);
      if (pick < 6) begin
        ev = any_item();
      end else if (pick < 130) begin
        ev = tick_item();
      end else if (pick < 150) begin
        ev = shaped_item(CMD_READ, 1'b1);
      end else if (pick < 164) begin
        ev = shaped_item(CMD_READ, 1'b0);
      end else if (pick < 182) begin
        ev = shaped_item(CMD_WRITE, 1'b1);
      end else if (pick < 190) begin
        ev = shaped_item(CMD_WRITE, 1'b0);
        ev.write_data[1:0] = pick_divider();
      end else if (pick < 197) begin
        ev = shaped_item(CMD_REWIND, 1'($urandom));
      end else begin
        wait_drained();
        ev = shaped_item(CMD_READ, 1'b0);
      end
      send_event(ev);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stalled divider, ignored data write, motor start, first slot right after
  // the divider is set, overrun, switch to writing with rewind, transmit,
  // rewind command, master reset.
  task automatic test_directed_events();
    in_item_t ev;
    int k;
    ev = shaped_item(CMD_TICK, 1'b0);
    ev.tick_cycles = 8'hFF;
    send_event(ev);                         // motor off, divider stalled
    ev = shaped_item(CMD_WRITE, 1'b1);
    ev.write_data = 8'h00;
    send_event(ev);                         // data write with motor off: dropped
    send_event(shaped_item(CMD_READ, 1'b0)); // status read starts the tape
    ev = shaped_item(CMD_TICK, 1'b1);
    ev.tick_cycles = 8'hFF;
    send_event(ev);                         // motor on, still no control write

    configure(16'd256, 1'b1, 1'b1, 10'd1023);
    ev = shaped_item(CMD_WRITE, 1'b0);
    ev.write_data = {3'b000, 3'd2, DIV_SEL_1};  // /1, 10-bit frame
    send_event(ev);
    ev = shaped_item(CMD_TICK, 1'b0);
    ev.tick_cycles   = 8'hFF;
    ev.tape_in_valid = 1'b1;
    ev.tape_in_byte  = 8'h00;
    send_event(ev);                         // bits_left starts at 0: slot now
    for (k = 0; k < 10; k++) begin
      ev = shaped_item(CMD_TICK, 1'b0);
      ev.tick_cycles   = (k == 0) ? 8'h00 : 8'h01;
      ev.tape_in_valid = 1'b1;
      ev.tape_in_byte  = 8'hFF;
      send_event(ev);                       // tenth one overruns
    end
    send_event(shaped_item(CMD_READ, 1'b0));
    send_event(shaped_item(CMD_READ, 1'b1));
    ev = shaped_item(CMD_WRITE, 1'b1);
    ev.write_data = 8'hFF;
    send_event(ev);                         // into writing mode, rewind asked
    for (k = 0; k < 10; k++) begin
      ev = shaped_item(CMD_TICK, 1'b1);
      ev.tick_cycles = 8'h80;
      send_event(ev);                       // transmit byte goes out on the tenth
    end
    send_event(shaped_item(CMD_REWIND, 1'b0));
    ev = shaped_item(CMD_WRITE, 1'b0);
    ev.write_data = 8'hFF;                  // master reset, word select 7
    send_event(ev);
    send_event(shaped_item(CMD_READ, 1'b0));
  endtask

  // Base period 0 ticks on every tick event; activity limit 0 stops the tape
  // at the first slot. Then the longest base period.
  task automatic test_register_extremes();
    configure(16'd0, 1'b1, 1'b1, 10'd0);
    run_session(40);
    configure(16'hFFFF, 1'b1, 1'b1, 10'd1023);
    run_session(200);
  endtask

  // Full-scale ticks against a base period of 256 push the accumulator into
  // saturation, with slots running all along. No gaps here.
  task automatic test_accum_saturation();
    in_item_t ev;
    int k;
    configure(16'd256, 1'b1, 1'b1, 10'd1023);
    steady = 1'b1;
    ev = shaped_item(CMD_WRITE, 1'b0);
    ev.write_data[1:0] = DIV_SEL_1;
    send_event(ev);
    send_event(shaped_item(CMD_READ, 1'b0));
    for (k = 0; k < 300; k++) begin
      if (k % 9 == 8) begin
        ev = shaped_item(CMD_READ, 1'($urandom));
      end else begin
        ev = shaped_item(CMD_TICK, 1'($urandom));
        ev.tick_cycles   = 8'hFF;
        ev.tape_in_valid = ($urandom_range(0, 9) != 0);
      end
      send_event(ev);
    end
    steady = 1'b0;
  endtask

  // short activity limits: the tape stops between bus accesses
  task automatic test_activity_timeout();
    configure(16'd400, 1'b1, 1'b1, 10'd1);
    run_session(200);
    configure(16'd300, 1'b1, 1'b1, 10'd5);
    run_session(180);
  endtask

  // missing input source and/or output sink
  task automatic test_detached_tape();
    configure(16'd700, 1'b0, 1'b1, 10'd40);
    run_session(180);
    configure(16'd350, 1'b1, 1'b0, 10'd40);
    run_session(180);
    configure(16'd500, 1'b0, 1'b0, 10'd20);
    run_session(60);
  endtask

  // random settings; the middle phase runs with no gaps at all
  task automatic test_random_settings();
    int i;
    for (i = 0; i < 3; i++) begin
      configure(16'($urandom_range(256, 3000)), 1'($urandom), 1'($urandom),
                10'($urandom_range(1, 80)));
      steady = (i == 1);
      run_session(120);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls on ready, and the reply checker
  // ---------------------------------------------------------------------------
  initial begin : result_drain
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected reply, expected none, actual 0x%0h", $time, out_ch.item);
      end else begin
        want = replies_due.pop_front();
        check_field("read_data", want.read_data, out_ch.item.read_data);
        check_field("tape_in_take", {7'd0, want.tape_in_take},
                    {7'd0, out_ch.item.tape_in_take});
        check_field("tape_out_valid", {7'd0, want.tape_out_valid},
                    {7'd0, out_ch.item.tape_out_valid});
        check_field("tape_out_byte", want.tape_out_byte, out_ch.item.tape_out_byte);
        check_field("rewind_request", {7'd0, want.rewind_request},
                    {7'd0, out_ch.item.rewind_request});
        check_field("running", {7'd0, want.running}, {7'd0, out_ch.item.running});
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer anywhere means a hang.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.item       <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_BASE_PERIOD;
    cfg_ch.reg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_register_extremes();
    test_accum_saturation();
    test_activity_timeout();
    test_detached_tape();
    test_random_settings();

    // everything sent: let the last replies come home, then a short tail to
    // catch anything extra
    wait_drained();
    repeat (SETTLE_TAIL) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
